// ===== rtl/ogcc_pkg.sv =====
// ----------------------------------------------------------------------------
// ogcc_pkg
// Shared types, codes and defaults for the occupancy grid cell counter.
// ----------------------------------------------------------------------------
package ogcc_pkg;

    // default grid geometry and counter width
    localparam int GRID_WIDTH_DEF  = 256;
    localparam int GRID_HEIGHT_DEF = 256;
    localparam int COUNT_BITS_DEF  = 16;

    // fixed field widths
    localparam int KIND_BITS   = 2;
    localparam int COORD_BITS  = 8;
    localparam int COLOR_BITS  = 24;
    localparam int OCC_BITS    = 2;
    localparam int OUT_CNT_BITS = 16;
    localparam int MW_BITS     = 13;
    localparam int HW_BITS     = 13;
    localparam int THR_BITS    = 14;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 24;

    // item kinds
    localparam logic [KIND_BITS-1:0] KIND_ADD    = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_REMOVE = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_READ   = 2'd2;

    // occupancy codes
    localparam logic [OCC_BITS-1:0] OCC_UNKNOWN  = 2'd0;
    localparam logic [OCC_BITS-1:0] OCC_FREE     = 2'd1;
    localparam logic [OCC_BITS-1:0] OCC_OCCUPIED = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_MISS_WEIGHT   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HIT_WEIGHT    = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD     = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MISSING_COLOR = 2'd3;

    // configuration reset values
    localparam logic signed [MW_BITS-1:0]  MISS_WEIGHT_RST = -13'sd104;
    localparam logic [HW_BITS-1:0]         HIT_WEIGHT_RST  = 13'd217;
    localparam logic signed [THR_BITS-1:0] THRESHOLD_RST   = 14'sd0;
    localparam logic [COLOR_BITS-1:0]      MISSING_COLOR_RST = 24'd0;

    // configuration as seen by the datapath
    typedef struct packed {
        logic signed [MW_BITS-1:0]  miss_weight;
        logic [HW_BITS-1:0]         hit_weight;
        logic signed [THR_BITS-1:0] threshold;
        logic [COLOR_BITS-1:0]      missing_color;
    } ogcc_cfg_t;

    // controller to datapath commands
    typedef struct packed {
        logic clr_step;
        logic capture;
        logic mem_read;
        logic update;
        logic mult;
        logic load_out;
    } ogcc_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic clr_last;
        logic out_free;
    } ogcc_status_t;

endpackage

// ===== rtl/ogcc_ctrl.sv =====
// ----------------------------------------------------------------------------
// ogcc_ctrl
// Sequencer: clearing pass after reset, then read, update, multiply and
// classify for one item at a time.
// ----------------------------------------------------------------------------
module ogcc_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  ogcc_pkg::ogcc_status_t status,
    output ogcc_pkg::ogcc_cmd_t   cmd,
    output logic                  in_stall
);

    typedef enum logic [2:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_MULT,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:  if (status.clr_last) state_next = ST_IDLE;
            ST_IDLE:   if (in_valid) state_next = ST_READ;
            ST_READ:   state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_MULT;
            ST_MULT:   state_next = ST_DONE;
            ST_DONE:   if (status.out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // command decode
    always_comb
    begin
        cmd.clr_step = (state_reg == ST_CLEAR);
        cmd.capture  = (state_reg == ST_IDLE) && in_valid;
        cmd.mem_read = (state_reg == ST_READ);
        cmd.update   = (state_reg == ST_UPDATE);
        cmd.mult     = (state_reg == ST_MULT);
        cmd.load_out = (state_reg == ST_DONE) && status.out_free;
    end

    assign in_stall = (state_reg != ST_IDLE);

endmodule

// ===== rtl/ogcc_datapath.sv =====
// ----------------------------------------------------------------------------
// ogcc_datapath
// Cell memory, read-modify-write of the counts, log-odds products and the
// output register.
// ----------------------------------------------------------------------------
module ogcc_datapath
#(
    parameter int GRID_WIDTH  = ogcc_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = ogcc_pkg::GRID_HEIGHT_DEF,
    parameter int COUNT_BITS  = ogcc_pkg::COUNT_BITS_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  ogcc_pkg::ogcc_cmd_t                   cmd,
    output ogcc_pkg::ogcc_status_t                status,
    input  ogcc_pkg::ogcc_cfg_t                   cfg,
    input  logic [ogcc_pkg::KIND_BITS-1:0]        kind,
    input  logic [ogcc_pkg::COORD_BITS-1:0]       cell_x,
    input  logic [ogcc_pkg::COORD_BITS-1:0]       cell_y,
    input  logic                                  is_free,
    input  logic [ogcc_pkg::COLOR_BITS-1:0]       point_color,
    input  logic                                  out_stall,
    output logic                                  out_valid,
    output logic [ogcc_pkg::OCC_BITS-1:0]         occupancy,
    output logic [ogcc_pkg::OUT_CNT_BITS-1:0]     miss_count,
    output logic [ogcc_pkg::OUT_CNT_BITS-1:0]     hit_count,
    output logic [ogcc_pkg::COLOR_BITS-1:0]       cell_color,
    output logic                                  count_error
);

    localparam int CELLS     = GRID_WIDTH * GRID_HEIGHT;
    localparam int ADDR_BITS = $clog2(CELLS);
    localparam int CB        = ogcc_pkg::COLOR_BITS;
    localparam int WORD_BITS = 2 * COUNT_BITS + CB + 1;
    localparam int MP_BITS   = COUNT_BITS + ogcc_pkg::MW_BITS + 1;
    localparam int HP_BITS   = COUNT_BITS + ogcc_pkg::HW_BITS;
    localparam int SUM_BITS  = COUNT_BITS + ogcc_pkg::MW_BITS + 2;

    // cell memory: written bit, colour, hit count, miss count
    logic [WORD_BITS-1:0] mem [CELLS];
    logic [WORD_BITS-1:0] rd_data_reg;
    logic                 mem_we;
    logic [ADDR_BITS-1:0] mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;

    // clearing pass counter
    logic [ADDR_BITS-1:0] clr_addr_reg;

    // captured item
    logic [ogcc_pkg::KIND_BITS-1:0]  kind_reg;
    logic                            free_reg;
    logic [CB-1:0]                   color_in_reg;
    logic [ADDR_BITS-1:0]            idx_reg;
    logic                            oob_reg;
    logic [ADDR_BITS-1:0]            idx_next;
    logic                            oob_next;

    // update stage results
    logic [COUNT_BITS-1:0] miss_res_reg;
    logic [COUNT_BITS-1:0] hit_res_reg;
    logic [CB-1:0]         color_res_reg;
    logic                  err_res_reg;

    // read-modify-write of the cell
    logic [COUNT_BITS-1:0] cur_miss;
    logic [COUNT_BITS-1:0] cur_hit;
    logic [CB-1:0]         cur_color;
    logic                  cur_written;
    logic [COUNT_BITS-1:0] sel_cnt;
    logic [COUNT_BITS-1:0] new_cnt;
    logic                  new_err;
    logic [COUNT_BITS-1:0] new_miss;
    logic [COUNT_BITS-1:0] new_hit;
    logic [CB-1:0]         new_color;
    logic                  new_written;
    logic                  is_write_kind;

    // products
    logic signed [MP_BITS-1:0] miss_prod_reg;
    logic [HP_BITS-1:0]        hit_prod_reg;
    logic                      empty_reg;
    logic signed [SUM_BITS-1:0] lo_sum;
    logic [ogcc_pkg::OCC_BITS-1:0] occ_next;

    // output register
    logic                                out_valid_reg;
    logic [ogcc_pkg::OCC_BITS-1:0]       occ_reg;
    logic [ogcc_pkg::OUT_CNT_BITS-1:0]   miss_out_reg;
    logic [ogcc_pkg::OUT_CNT_BITS-1:0]   hit_out_reg;
    logic [CB-1:0]                       color_out_reg;
    logic                                err_out_reg;

    // cell index and grid bounds
    assign idx_next = ADDR_BITS'(32'(cell_y) * 32'(GRID_WIDTH) + 32'(cell_x));
    assign oob_next = (32'(cell_x) >= 32'(GRID_WIDTH)) || (32'(cell_y) >= 32'(GRID_HEIGHT));

    // field split of the read word
    assign cur_miss    = rd_data_reg[COUNT_BITS-1:0];
    assign cur_hit     = rd_data_reg[2*COUNT_BITS-1:COUNT_BITS];
    assign cur_color   = rd_data_reg[2*COUNT_BITS+CB-1:2*COUNT_BITS];
    assign cur_written = rd_data_reg[WORD_BITS-1];

    // count update with saturation and floor at zero
    always_comb
    begin
        sel_cnt = free_reg ? cur_miss : cur_hit;
        new_cnt = sel_cnt;
        new_err = 1'b0;
        case (kind_reg)
            ogcc_pkg::KIND_ADD:
            begin
                if (sel_cnt == {COUNT_BITS{1'b1}})
                begin
                    new_err = 1'b1;
                end
                else
                begin
                    new_cnt = sel_cnt + COUNT_BITS'(1);
                end
            end
            ogcc_pkg::KIND_REMOVE:
            begin
                if (sel_cnt == '0)
                begin
                    new_err = 1'b1;
                end
                else
                begin
                    new_cnt = sel_cnt - COUNT_BITS'(1);
                end
            end
            default:
            begin
                new_cnt = sel_cnt;
                new_err = 1'b0;
            end
        endcase
        new_miss    = free_reg ? new_cnt : cur_miss;
        new_hit     = free_reg ? cur_hit : new_cnt;
        new_color   = (kind_reg == ogcc_pkg::KIND_ADD) ? color_in_reg : cur_color;
        new_written = (kind_reg == ogcc_pkg::KIND_ADD) ? 1'b1 : cur_written;
    end

    assign is_write_kind = (kind_reg == ogcc_pkg::KIND_ADD) ||
                           (kind_reg == ogcc_pkg::KIND_REMOVE);

    // memory write port: clearing pass or write-back
    always_comb
    begin
        if (cmd.clr_step)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = cmd.update && !oob_reg && is_write_kind;
            mem_waddr = idx_reg;
            mem_wdata = {new_written, new_color, new_hit, new_miss};
        end
    end

    // cell memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.mem_read)
        begin
            rd_data_reg <= mem[idx_reg];
        end
    end

    // clearing pass address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clr_step)
        begin
            clr_addr_reg <= clr_addr_reg + ADDR_BITS'(1);
        end
    end

    assign status.clr_last = (clr_addr_reg == ADDR_BITS'(CELLS - 1));
    assign status.out_free = !out_valid_reg || !out_stall;

    // log-odds sum and threshold compare
    always_comb
    begin
        lo_sum = SUM_BITS'(miss_prod_reg) + SUM_BITS'($signed({1'b0, hit_prod_reg}));
        if (empty_reg)
        begin
            occ_next = ogcc_pkg::OCC_UNKNOWN;
        end
        else if (lo_sum >= SUM_BITS'(cfg.threshold))
        begin
            occ_next = ogcc_pkg::OCC_OCCUPIED;
        end
        else
        begin
            occ_next = ogcc_pkg::OCC_FREE;
        end
    end

    // item pipeline registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg     <= kind;
            free_reg     <= is_free;
            color_in_reg <= point_color;
            idx_reg      <= idx_next;
            oob_reg      <= oob_next;
        end
        if (cmd.update)
        begin
            if (oob_reg)
            begin
                miss_res_reg  <= '0;
                hit_res_reg   <= '0;
                color_res_reg <= cfg.missing_color;
                err_res_reg   <= 1'b1;
            end
            else
            begin
                miss_res_reg  <= new_miss;
                hit_res_reg   <= new_hit;
                color_res_reg <= new_written ? new_color : cfg.missing_color;
                err_res_reg   <= new_err;
            end
        end
        if (cmd.mult)
        begin
            miss_prod_reg <= $signed({1'b0, miss_res_reg}) * cfg.miss_weight;
            hit_prod_reg  <= hit_res_reg * cfg.hit_weight;
            empty_reg     <= (miss_res_reg == '0) && (hit_res_reg == '0);
        end
        if (cmd.load_out)
        begin
            occ_reg       <= occ_next;
            miss_out_reg  <= ogcc_pkg::OUT_CNT_BITS'(miss_res_reg);
            hit_out_reg   <= ogcc_pkg::OUT_CNT_BITS'(hit_res_reg);
            color_out_reg <= color_res_reg;
            err_out_reg   <= err_res_reg;
        end
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign occupancy   = occ_reg;
    assign miss_count  = miss_out_reg;
    assign hit_count   = hit_out_reg;
    assign cell_color  = color_out_reg;
    assign count_error = err_out_reg;

endmodule

// ===== rtl/occupancy_grid_cell_counter_top.sv =====
// ----------------------------------------------------------------------------
// occupancy_grid_cell_counter_top
// Per-cell miss/hit counters with colour words and log-odds classification.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the cell memory, one cell
// a cycle, GRID_WIDTH*GRID_HEIGHT cells (65536 at the defaults); in_stall
// stays high during it while configuration writes are taken. From then on
// one item is in work at a time: accept, memory read, count update with
// write-back, the two log-odds multiplies, then classification into the
// output register. The next item is accepted while a result still waits
// in the output register.
module occupancy_grid_cell_counter_top
#(
    parameter int GRID_WIDTH  = ogcc_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = ogcc_pkg::GRID_HEIGHT_DEF,
    parameter int COUNT_BITS  = ogcc_pkg::COUNT_BITS_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [ogcc_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [ogcc_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [ogcc_pkg::KIND_BITS-1:0]        kind,
    input  logic [ogcc_pkg::COORD_BITS-1:0]       cell_x,
    input  logic [ogcc_pkg::COORD_BITS-1:0]       cell_y,
    input  logic                                  is_free,
    input  logic [ogcc_pkg::COLOR_BITS-1:0]       point_color,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [ogcc_pkg::OCC_BITS-1:0]         occupancy,
    output logic [ogcc_pkg::OUT_CNT_BITS-1:0]     miss_count,
    output logic [ogcc_pkg::OUT_CNT_BITS-1:0]     hit_count,
    output logic [ogcc_pkg::COLOR_BITS-1:0]       cell_color,
    output logic                                  count_error
);

    ogcc_pkg::ogcc_cfg_t    cfg_reg;
    ogcc_pkg::ogcc_cmd_t    cmd;
    ogcc_pkg::ogcc_status_t status;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.miss_weight   <= ogcc_pkg::MISS_WEIGHT_RST;
            cfg_reg.hit_weight    <= ogcc_pkg::HIT_WEIGHT_RST;
            cfg_reg.threshold     <= ogcc_pkg::THRESHOLD_RST;
            cfg_reg.missing_color <= ogcc_pkg::MISSING_COLOR_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                ogcc_pkg::CFG_MISS_WEIGHT:
                    cfg_reg.miss_weight <= $signed(cfg_data[ogcc_pkg::MW_BITS-1:0]);
                ogcc_pkg::CFG_HIT_WEIGHT:
                    cfg_reg.hit_weight <= cfg_data[ogcc_pkg::HW_BITS-1:0];
                ogcc_pkg::CFG_THRESHOLD:
                    cfg_reg.threshold <= $signed(cfg_data[ogcc_pkg::THR_BITS-1:0]);
                ogcc_pkg::CFG_MISSING_COLOR:
                    cfg_reg.missing_color <= cfg_data[ogcc_pkg::COLOR_BITS-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    // sequencer
    ogcc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .status   (status),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    // cell memory and arithmetic
    ogcc_datapath
    #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT),
        .COUNT_BITS  (COUNT_BITS)
    )
    u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg         (cfg_reg),
        .kind        (kind),
        .cell_x      (cell_x),
        .cell_y      (cell_y),
        .is_free     (is_free),
        .point_color (point_color),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .occupancy   (occupancy),
        .miss_count  (miss_count),
        .hit_count   (hit_count),
        .cell_color  (cell_color),
        .count_error (count_error)
    );

    // one item in work at a time
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted while an item is in work");

    // an unknown cell has both counts at zero
    a_unknown_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (occupancy == ogcc_pkg::OCC_UNKNOWN)) |->
        ((miss_count == '0) && (hit_count == '0)))
        else $error("unknown cell with nonzero count");

    // a new result only comes from an item in work
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result raised without an item in work");

endmodule

// ===== tb/sv/occupancy_grid_cell_counter_top_tb.sv =====
// ----------------------------------------------------------------------------
// occupancy_grid_cell_counter_top_tb
// Self-checking bench for the grid cell counter: a queue-fed driver sends
// add, remove, read and spare-kind items with random gaps, a monitor with random stalls
// compares every result against a cell-state predictor kept in the bench.
// Covers reset defaults, count build-up and underflow, colour handling,
// several weight/threshold settings and a long output hold-off.
// ----------------------------------------------------------------------------
module occupancy_grid_cell_counter_top_tb;

    import ogcc_pkg::*;

    localparam logic [KIND_BITS-1:0]    KIND_SPARE     = 2'd3;
    localparam logic [OUT_CNT_BITS-1:0] COUNT_MAX      = 16'hFFFF;
    localparam int                      HOLD_CYCLES    = 300;
    localparam int                      WATCHDOG_LIMIT = 300000;
    localparam int                      MAX_REPORTS    = 10;

    // one point item as queued for the driver
    typedef struct {
        logic [KIND_BITS-1:0]  kind;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic                  free;
        logic [COLOR_BITS-1:0] color;
        int                    gap;
    } point_t;

    // one cell answer
    typedef struct packed {
        logic [OCC_BITS-1:0]     occ;
        logic [OUT_CNT_BITS-1:0] misses;
        logic [OUT_CNT_BITS-1:0] hits;
        logic [COLOR_BITS-1:0]   color;
        logic                    err;
    } cell_result_t;

    logic                     clk         = 1'b0;
    logic                     rst_n       = 1'b0;
    logic                     cfg_write   = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index   = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data    = '0;
    logic                     in_valid    = 1'b0;
    logic                     in_stall;
    logic [KIND_BITS-1:0]     kind        = '0;
    logic [COORD_BITS-1:0]    cell_x      = '0;
    logic [COORD_BITS-1:0]    cell_y      = '0;
    logic                     is_free     = 1'b0;
    logic [COLOR_BITS-1:0]    point_color = '0;
    logic                     out_valid;
    logic                     out_stall   = 1'b0;
    logic [OCC_BITS-1:0]      occupancy;
    logic [OUT_CNT_BITS-1:0]  miss_count;
    logic [OUT_CNT_BITS-1:0]  hit_count;
    logic [COLOR_BITS-1:0]    cell_color;
    logic                     count_error;

    // bench state
    point_t       pending_points[$];
    cell_result_t expected_cells[$];
    point_t       tx_item;
    int           tx_gap       = 0;
    int           rx_wait      = 0;
    bit           tx_quiet     = 1'b0;
    bit           rx_quiet     = 1'b0;
    int           hold_asks    = 0;
    int           holds_given  = 0;
    int           mismatches   = 0;
    int           results_seen = 0;
    int           idle_cycles  = 0;

    // predicted grid contents and configuration
    bit [OUT_CNT_BITS-1:0] miss_tab  [bit [15:0]];
    bit [OUT_CNT_BITS-1:0] hit_tab   [bit [15:0]];
    bit [COLOR_BITS-1:0]   color_tab [bit [15:0]];
    ogcc_cfg_t             cfg_shadow;

    occupancy_grid_cell_counter_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .cell_x      (cell_x),
        .cell_y      (cell_y),
        .is_free     (is_free),
        .point_color (point_color),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .occupancy   (occupancy),
        .miss_count  (miss_count),
        .hit_count   (hit_count),
        .cell_color  (cell_color),
        .count_error (count_error)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // apply one point to the predicted grid and return the cell answer
    function automatic cell_result_t apply_point(input point_t p);
        bit [15:0]               cell_idx;
        logic [OUT_CNT_BITS-1:0] misses;
        logic [OUT_CNT_BITS-1:0] hits;
        logic                    err;
        longint                  log_odds;
        cell_result_t            r;
        cell_idx = {p.y, p.x};
        misses   = '0;
        hits     = '0;
        err      = 1'b0;
        if (miss_tab.exists(cell_idx))
            misses = miss_tab[cell_idx];
        if (hit_tab.exists(cell_idx))
            hits = hit_tab[cell_idx];
        if (p.kind == KIND_ADD)
        begin
            // counts stick at the top and flag it
            if (p.free)
            begin
                if (misses == COUNT_MAX)
                    err = 1'b1;
                else
                    misses = misses + 1'b1;
            end
            else
            begin
                if (hits == COUNT_MAX)
                    err = 1'b1;
                else
                    hits = hits + 1'b1;
            end
            color_tab[cell_idx] = p.color;
        end
        else if (p.kind == KIND_REMOVE)
        begin
            // counts stop at zero and flag it
            if (p.free)
            begin
                if (misses == '0)
                    err = 1'b1;
                else
                    misses = misses - 1'b1;
            end
            else
            begin
                if (hits == '0)
                    err = 1'b1;
                else
                    hits = hits - 1'b1;
            end
        end
        miss_tab[cell_idx] = misses;
        hit_tab[cell_idx]  = hits;

        // exact signed Q22.8 log-odds against the threshold
        log_odds = longint'(misses) * longint'($signed(cfg_shadow.miss_weight))
                 + longint'(hits) * longint'(cfg_shadow.hit_weight);
        if (misses == '0 && hits == '0)
            r.occ = OCC_UNKNOWN;
        else if (log_odds >= longint'($signed(cfg_shadow.threshold)))
            r.occ = OCC_OCCUPIED;
        else
            r.occ = OCC_FREE;
        r.misses = misses;
        r.hits   = hits;
        r.err    = err;
        if (color_tab.exists(cell_idx))
            r.color = color_tab[cell_idx];
        else
            r.color = cfg_shadow.missing_color;
        return r;
    endfunction

    // driver: present queued items, predict each one on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            tx_gap = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_cells.push_back(apply_point(tx_item));
            if (!in_valid || !in_stall)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap = tx_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_points.size() > 0)
                begin
                    tx_item = pending_points.pop_front();
                    tx_gap  = tx_item.gap;
                    in_valid    <= 1'b1;
                    kind        <= tx_item.kind;
                    cell_x      <= tx_item.x;
                    cell_y      <= tx_item.y;
                    is_free     <= tx_item.free;
                    point_color <= tx_item.color;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: random stalls, long hold-off on request, compare results
    always @(posedge clk or negedge rst_n)
    begin
        cell_result_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            rx_wait = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen = results_seen + 1;
                if (expected_cells.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= MAX_REPORTS)
                        $display("result %0d arrived with no item pending", results_seen);
                end
                else
                begin
                    want = expected_cells.pop_front();
                    if (occupancy !== want.occ || miss_count !== want.misses ||
                        hit_count !== want.hits || cell_color !== want.color ||
                        count_error !== want.err)
                    begin
                        mismatches = mismatches + 1;
                        if (mismatches <= MAX_REPORTS)
                            $display({"result %0d: expected occ %0d miss %0d hit %0d ",
                                      "color %h err %0d, got occ %0d miss %0d hit %0d ",
                                      "color %h err %0d"},
                                     results_seen, want.occ, want.misses, want.hits,
                                     want.color, want.err, occupancy, miss_count,
                                     hit_count, cell_color, count_error);
                    end
                end
                rx_wait = rx_quiet ? 0 : $urandom_range(0, 9);
            end
            else if (rx_wait > 0)
            begin
                rx_wait = rx_wait - 1;
            end
            if (hold_asks != holds_given)
            begin
                rx_wait     = HOLD_CYCLES;
                holds_given = holds_given + 1;
            end
            out_stall <= (rx_wait != 0);
        end
    end

    // watchdog on cycles without any item moving
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("occupancy_grid_cell_counter_top: mismatch");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // register write, only while the block is idle
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_BITS-1:0];
        case (idx)
            CFG_MISS_WEIGHT:   cfg_shadow.miss_weight   = value[MW_BITS-1:0];
            CFG_HIT_WEIGHT:    cfg_shadow.hit_weight    = value[HW_BITS-1:0];
            CFG_THRESHOLD:     cfg_shadow.threshold     = value[THR_BITS-1:0];
            CFG_MISSING_COLOR: cfg_shadow.missing_color = value[COLOR_BITS-1:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic set_weights(input int mw, input int hw, input int thr, input int mc);
        write_reg(CFG_MISS_WEIGHT, mw);
        write_reg(CFG_HIT_WEIGHT, hw);
        write_reg(CFG_THRESHOLD, thr);
        write_reg(CFG_MISSING_COLOR, mc);
    endtask

    task automatic queue_point(input logic [KIND_BITS-1:0] k, input int x, input int y,
                               input bit free, input int color);
        point_t p;
        p.kind  = k;
        p.x     = x[COORD_BITS-1:0];
        p.y     = y[COORD_BITS-1:0];
        p.free  = free;
        p.color = color[COLOR_BITS-1:0];
        p.gap   = tx_quiet ? 0 : $urandom_range(0, 9);
        pending_points.push_back(p);
    endtask

    // wait until every item went through and the pipeline has settled
    task automatic drain();
        while (pending_points.size() != 0 || in_valid || expected_cells.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // random traffic around a few hot cells so counts build up
    task automatic queue_random(input int n);
        int               hot_x[6];
        int               hot_y[6];
        int               pick;
        int               roll;
        logic [KIND_BITS-1:0] k;
        for (int i = 0; i < 6; i++)
        begin
            hot_x[i] = $urandom_range(0, 255);
            hot_y[i] = $urandom_range(0, 255);
        end
        for (int i = 0; i < n; i++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 50)
                k = KIND_ADD;
            else if (roll < 75)
                k = KIND_REMOVE;
            else if (roll < 95)
                k = KIND_READ;
            else
                k = KIND_SPARE;
            if ($urandom_range(0, 4) == 0)
                queue_point(k, $urandom_range(0, 255), $urandom_range(0, 255),
                            $urandom_range(0, 1), $urandom());
            else
            begin
                pick = $urandom_range(0, 5);
                queue_point(k, hot_x[pick], hot_y[pick], $urandom_range(0, 1), $urandom());
            end
        end
    endtask

    // stimulus sequence
    initial
    begin
        cfg_shadow = {MISS_WEIGHT_RST, HIT_WEIGHT_RST, THRESHOLD_RST, MISSING_COLOR_RST};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed items at reset settings
        queue_point(KIND_READ,   0,   0,   1'b0, 24'h123456);
        queue_point(KIND_SPARE,  255, 255, 1'b1, 24'hFFFFFF);
        queue_point(KIND_REMOVE, 255, 0,   1'b1, 24'h000000);
        queue_point(KIND_REMOVE, 0,   255, 1'b0, 24'h000000);
        queue_point(KIND_ADD,    0,   0,   1'b1, 24'hFFFFFF);
        queue_point(KIND_ADD,    0,   0,   1'b0, 24'h000000);
        queue_point(KIND_READ,   0,   0,   1'b1, 24'hABCDEF);
        queue_point(KIND_REMOVE, 0,   0,   1'b1, 24'hFFFFFF);
        queue_point(KIND_REMOVE, 0,   0,   1'b0, 24'hFFFFFF);
        queue_point(KIND_REMOVE, 0,   0,   1'b0, 24'h555555);
        tx_quiet = 1'b1;
        queue_point(KIND_ADD,    255, 255, 1'b0, 24'hA5A5A5);
        queue_point(KIND_ADD,    255, 255, 1'b0, 24'h5A5A5A);
        queue_point(KIND_ADD,    255, 255, 1'b0, 24'hF0F0F0);
        queue_point(KIND_ADD,    255, 255, 1'b0, 24'h0F0F0F);
        queue_point(KIND_ADD,    255, 255, 1'b1, 24'h800001);
        queue_point(KIND_ADD,    255, 255, 1'b1, 24'h7FFFFE);
        tx_quiet = 1'b0;
        queue_point(KIND_SPARE,  255, 255, 1'b1, 24'h000000);
        queue_point(KIND_ADD,    128, 1,   1'b1, 24'h800001);
        queue_point(KIND_ADD,    128, 1,   1'b1, 24'h0000FF);
        queue_point(KIND_REMOVE, 255, 255, 1'b1, 24'hFFFFFF);
        queue_point(KIND_READ,   127, 254, 1'b0, 24'h000000);
        queue_point(KIND_READ,   128, 1,   1'b0, 24'h000000);
        drain();

        // zero weights: any seen cell is occupied
        set_weights(0, 0, 0, 24'hFFFFFF);
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        queue_random(110);
        drain();

        // both counts of one cell built up, back to back
        set_weights(-4096, 4096, 0, 24'h123456);
        for (int i = 0; i < 40; i++)
            queue_point(KIND_ADD, 200, 77, 1'b0, i * 37);
        for (int i = 0; i < 40; i++)
            queue_point(KIND_ADD, 200, 77, 1'b1, i * 101);
        queue_point(KIND_READ,   200, 77, 1'b0, 24'h000000);
        queue_point(KIND_REMOVE, 200, 77, 1'b0, 24'h000000);
        queue_point(KIND_REMOVE, 200, 77, 1'b1, 24'h000000);
        queue_point(KIND_ADD,    200, 77, 1'b1, 24'hC0FFEE);
        queue_point(KIND_SPARE,  200, 77, 1'b1, 24'h000000);
        drain();

        // top threshold; output held off while the sender keeps pushing
        set_weights(-4096, 4096, 4096, 24'h00FF00);
        tx_quiet  = 1'b1;
        rx_quiet  = 1'b0;
        hold_asks = hold_asks + 1;
        queue_random(110);
        drain();

        // no hit weight, bottom threshold
        set_weights(-4096, 0, -4096, $urandom());
        tx_quiet = 1'b0;
        queue_random(110);
        drain();

        // random settings within range
        set_weights(-int'($urandom_range(0, 4096)), $urandom_range(0, 4096),
                    int'($urandom_range(0, 8192)) - 4096, $urandom());
        rx_quiet = 1'b1;
        queue_random(110);
        drain();

        // back to the reset settings
        set_weights(-104, 217, 0, 0);
        rx_quiet = 1'b0;
        queue_random(110);
        drain();

        if (mismatches == 0)
            $display("occupancy_grid_cell_counter_top: match");
        else
            $display("occupancy_grid_cell_counter_top: mismatch");
        $finish;
    end

endmodule
